// ----- design/grpw_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the glyph row pixel writer.
// No dependencies; imported by every module of the block.
package grpw_pkg;

  localparam int GLYPH_WIDTH = 8;
  localparam int ROW_BITS    = 8;
  localparam int COL_W       = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
  localparam int COL_OUT_W   = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int SIN_W       = 64;
  localparam int MOUT_W      = 72;
  localparam logic [7:0] BPP_DIRECT = 8'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FB_BASE       = 3'd0,
    REG_SCREEN_WIDTH  = 3'd1,
    REG_SCREEN_HEIGHT = 3'd2,
    REG_LINE_PITCH    = 3'd3,
    REG_BITS_PER_PIX  = 3'd4,
    REG_RED_SHIFT     = 3'd5,
    REG_GREEN_SHIFT   = 3'd6,
    REG_BLUE_SHIFT    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] fb_base;
    logic [13:0] screen_width;
    logic [13:0] screen_height;
    logic [15:0] line_pitch;
    logic [7:0]  bits_per_pixel;
    logic [4:0]  red_shift;
    logic [4:0]  green_shift;
    logic [4:0]  blue_shift;
  } cfg_t;

  // One glyph row after clipping: row base address, packed pixel, live columns.
  typedef struct packed {
    logic [31:0]            base;
    logic [31:0]            word;
    logic [GLYPH_WIDTH-1:0] mask;
  } row_item_t;

endpackage

// ----- design/grpw_cfg.sv -----
`timescale 1ns / 1ps
// Configuration register file of the glyph row pixel writer.
// Depends on grpw_pkg.
module grpw_cfg
  import grpw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FB_BASE:       cfg.fb_base        <= cfg_data;
        REG_SCREEN_WIDTH:  cfg.screen_width   <= cfg_data[13:0];
        REG_SCREEN_HEIGHT: cfg.screen_height  <= cfg_data[13:0];
        REG_LINE_PITCH:    cfg.line_pitch     <= cfg_data[15:0];
        REG_BITS_PER_PIX:  cfg.bits_per_pixel <= cfg_data[7:0];
        REG_RED_SHIFT:     cfg.red_shift      <= cfg_data[4:0];
        REG_GREEN_SHIFT:   cfg.green_shift    <= cfg_data[4:0];
        REG_BLUE_SHIFT:    cfg.blue_shift     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- design/grpw_front.sv -----
`timescale 1ns / 1ps
// Three-stage front end: clip, row multiply and pixel pack, base address add.
// Depends on grpw_pkg.
module grpw_front
  import grpw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [15:0]  start_x,
  input  logic [15:0]  row_y,
  input  logic [7:0]   glyph_row,
  input  logic [23:0]  color,
  output logic         out_valid,
  input  logic         out_ready,
  output row_item_t    out_item
);

  logic                   v1, v2, v3;
  logic                   r1, r2, r3;
  logic [GLYPH_WIDTH-1:0] in_mask;
  logic                   row_ok;
  // stage 1
  logic [15:0]            x0_s1;
  logic [13:0]            y_s1;
  logic [23:0]            color_s1;
  logic [GLYPH_WIDTH-1:0] mask_s1;
  // stage 2
  logic [29:0]            prod_s2;
  logic [31:0]            pre_s2;
  logic [31:0]            word_s2;
  logic [GLYPH_WIDTH-1:0] mask_s2;
  logic [31:0]            word_pack;

  // Clip each column against the screen; rows off screen, a disabled
  // framebuffer or bits_per_pixel other than 32 give an empty mask.
  always_comb begin
    logic [16:0] xc;
    row_ok = (cfg.fb_base != '0) && (cfg.bits_per_pixel == BPP_DIRECT) &&
             !row_y[15] && (row_y < {2'b00, cfg.screen_height});
    for (int c = 0; c < GLYPH_WIDTH; c++) begin
      xc = {start_x[15], start_x} + 17'(c);
      if (GLYPH_WIDTH - 1 - c < ROW_BITS) begin
        in_mask[c] = glyph_row[(GLYPH_WIDTH - 1 - c) % ROW_BITS] && row_ok &&
                     !xc[16] && (xc[15:0] < {2'b00, cfg.screen_width});
      end else begin
        in_mask[c] = 1'b0;
      end
    end
  end

  always_comb begin
    word_pack = (32'(color_s1[23:16]) << cfg.red_shift) |
                (32'(color_s1[15:8])  << cfg.green_shift) |
                (32'(color_s1[7:0])   << cfg.blue_shift);
  end

  assign r3 = !v3 || out_ready;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      // rows with no visible pixel drop here
      if (r1) v1 <= in_valid && (in_mask != '0);
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      x0_s1    <= start_x;
      y_s1     <= row_y[13:0];
      color_s1 <= color;
      mask_s1  <= in_mask;
    end
    if (r2) begin
      prod_s2 <= {16'b0, y_s1} * {14'b0, cfg.line_pitch};
      pre_s2  <= cfg.fb_base + {{14{x0_s1[15]}}, x0_s1, 2'b00};
      word_s2 <= word_pack;
      mask_s2 <= mask_s1;
    end
    if (r3) begin
      out_item.base <= pre_s2 + {2'b00, prod_s2};
      out_item.word <= word_s2;
      out_item.mask <= mask_s2;
    end
  end

endmodule

// ----- design/grpw_emit.sv -----
`timescale 1ns / 1ps
// Pixel emitter: holds one clipped row and sends one write per live column,
// leftmost first, through a registered output. Depends on grpw_pkg.
module grpw_emit
  import grpw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  row_item_t            in_item,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          write_address,
  output logic [31:0]          pixel_word,
  output logic [COL_OUT_W-1:0] column,
  output logic                 last
);

  logic                   hold_valid;
  row_item_t              hold;
  logic [COL_W-1:0]       sel;
  logic [GLYPH_WIDTH-1:0] remaining;
  logic                   sel_last;
  logic                   out_load;
  logic                   fire;

  // leftmost live column
  always_comb begin
    sel = '0;
    for (int c = GLYPH_WIDTH - 1; c >= 0; c--) begin
      if (hold.mask[c]) sel = COL_W'(c);
    end
    remaining = hold.mask & ~(GLYPH_WIDTH'(1) << sel);
    sel_last  = (remaining == '0);
  end

  assign out_load = !m_tvalid || m_tready;
  assign fire     = hold_valid && out_load;
  assign in_ready = !hold_valid || (fire && sel_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (in_ready) hold_valid <= in_valid;
      if (out_load) m_tvalid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      hold <= in_item;
    end else if (fire) begin
      hold.mask <= remaining;
    end
    if (fire) begin
      write_address <= hold.base + 32'({sel, 2'b00});
      pixel_word    <= hold.word;
      column        <= COL_OUT_W'(sel);
      last          <= sel_last;
    end
  end

endmodule

// ----- design/glyph_row_pixel_writer.sv -----
`timescale 1ns / 1ps
// Glyph row pixel writer. Each input item is one glyph row (bit 7 is the
// leftmost column), the signed screen position of its leftmost pixel and a
// 24-bit RGB color; every set bit that lands inside the configured screen
// becomes one output item: a 32-bit write address (fb_base + y*pitch + x*4,
// wrapped), the pixel word with red, green and blue at their configured
// shifts, and the column, with tlast on the final write of the row. Nothing
// is produced while fb_base is zero or bits_per_pixel is not 32. Rate: the
// output side moves one write per cycle while m_tready is held high, so a row
// with n visible pixels (up to 8) gives n writes; rows with no visible pixel
// are dropped at the input. Three front stages (clip, multiply and pack,
// base add) run ahead, so a new row is taken while the previous one is still
// being written; the first write of a row passes these stages, the emitter's
// row hold and its output register. Write configuration only while idle.
// Depends on grpw_pkg, grpw_cfg, grpw_front and grpw_emit.
module glyph_row_pixel_writer
  import grpw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input rows
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [SIN_W-1:0]      s_tdata,   // start_x, row_y, glyph_row, color
  // output writes
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [MOUT_W-1:0]     m_tdata,   // write_address, pixel_word, column, zero pad
  output logic                  m_tlast
);

  cfg_t                 cfg;
  logic                 mid_valid;
  logic                 mid_ready;
  row_item_t            mid_item;
  logic [31:0]          write_address;
  logic [31:0]          pixel_word;
  logic [COL_OUT_W-1:0] column;

  grpw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // unpack the input item and run it through clip and address stages
  grpw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .start_x   (s_tdata[15:0]),
    .row_y     (s_tdata[31:16]),
    .glyph_row (s_tdata[39:32]),
    .color     (s_tdata[63:40]),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_item  (mid_item)
  );

  // serialize live columns onto the output
  grpw_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (mid_valid),
    .in_ready      (mid_ready),
    .in_item       (mid_item),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .write_address (write_address),
    .pixel_word    (pixel_word),
    .column        (column),
    .last          (m_tlast)
  );

  assign m_tdata = {{(MOUT_W - 64 - COL_OUT_W){1'b0}}, column, pixel_word, write_address};

endmodule

// ----- design/grpw_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the glyph row pixel writer, bound to the top level.
// Depends on grpw_pkg and glyph_row_pixel_writer.
module grpw_checker
  import grpw_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [MOUT_W-1:0] m_tdata,
  input logic              m_tlast
);

  logic                 in_row;
  logic [COL_OUT_W-1:0] prev_col;
  logic [31:0]          prev_word;

  // track the open row on the output side
  always_ff @(posedge clk) begin
    if (rst) begin
      in_row <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      in_row <= !m_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      prev_col  <= m_tdata[66:64];
      prev_word <= m_tdata[63:32];
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output item changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_col_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && in_row |-> m_tdata[66:64] > prev_col)
    else $error("columns of a row out of order");

  a_same_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && in_row |-> m_tdata[63:32] == prev_word)
    else $error("pixel word changed within a row");

endmodule

bind glyph_row_pixel_writer grpw_checker u_grpw_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
